// ===== rtl/foc_pkg.sv =====
// Shared types and constants for the FOC current-to-SVPWM step block.
`timescale 1ns / 1ps

package foc_pkg;

    // Operand and result widths of the shared multiply-accumulate unit.
    localparam int MAC_A_W   = 18;
    localparam int MAC_B_W   = 16;
    localparam int MAC_P_W   = MAC_A_W + MAC_B_W;
    localparam int MAC_ACC_W = MAC_P_W + 1;

    // Fixed coefficients of the control step.
    localparam logic signed [MAC_B_W-1:0] K_BETA     = 16'sd18918;
    localparam logic signed [MAC_B_W-1:0] K_FILT_OLD = 16'sd20317;
    localparam logic signed [MAC_B_W-1:0] K_FILT_NEW = 16'sd12451;
    localparam logic signed [MAC_B_W-1:0] K_SQRT3    = 16'sd3547;
    localparam logic signed [MAC_B_W-1:0] K_SVM_FULL = 16'sd255;
    localparam logic signed [15:0]        REG_POS    = 16'sd16384;
    localparam logic signed [15:0]        REG_NEG    = -16'sd16384;

    // Sector codes: bit 0 is X positive, bit 1 is Y positive, bit 2 is Z positive.
    localparam logic [2:0] SEC_NONE = 3'b000;
    localparam logic [2:0] SEC_X    = 3'b001;
    localparam logic [2:0] SEC_Y    = 3'b010;
    localparam logic [2:0] SEC_XY   = 3'b011;
    localparam logic [2:0] SEC_Z    = 3'b100;
    localparam logic [2:0] SEC_XZ   = 3'b101;
    localparam logic [2:0] SEC_YZ   = 3'b110;
    localparam logic [2:0] SEC_ALL  = 3'b111;

    // Accumulate modes of the shared unit.
    typedef enum logic [1:0] {
        MAC_LOAD,
        MAC_ADD,
        MAC_SUB
    } mac_mode_t;

    // One command to the shared unit.
    typedef struct packed {
        logic                 vld;
        mac_mode_t            mode;
        logic [MAC_A_W-1:0]   a;
        logic [MAC_B_W-1:0]   b;
    } mac_cmd_t;

    // Sequencer steps.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_BETA,
        ST_PARK_A,
        ST_PARK_B,
        ST_FILT_A,
        ST_FILT_B,
        ST_VA_Q,
        ST_FILT_WR,
        ST_REG,
        ST_VA_D,
        ST_VB_D,
        ST_VB_Q,
        ST_XS,
        ST_T,
        ST_XS_WR,
        ST_YZ,
        ST_ZS,
        ST_YS,
        ST_ZS_WR,
        ST_YS_WR,
        ST_OUT
    } seq_state_t;

endpackage

// ===== rtl/foc_current_to_svpwm_step.sv =====
// Top level: FOC current loop to SVPWM duty step, sequenced over one shared MAC.
//
//  Channel | Direction | Handshake            | Word
//  --------+-----------+----------------------+------------------------------------------
//  input   | in        | in_valid / in_ready  | phase currents, sine, cosine, q command
//  output  | out       | out_valid / out_ready| three duties, sector, d voltage
//
// An accepted word is worked through the sequencer steps until its result sits in the
// output register, and the block takes a new word only after that result is loaded. The
// steps are set by thirteen products that go one after another through the single
// multiply-accumulate unit, each held in the product register before it is accumulated.
// Reset empties the output register, returns to idle and clears the d-current filter
// and the flux integrator. If a result is still waiting, the next word is worked
// through and holds in its last step until the output register is free.
`timescale 1ns / 1ps

module foc_current_to_svpwm_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] phase_a_current,
    input  logic signed [15:0] phase_b_current,
    input  logic signed [15:0] angle_sine,
    input  logic signed [15:0] angle_cosine,
    input  logic signed [15:0] q_voltage_cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [14:0]        duty_a,
    output logic [14:0]        duty_b,
    output logic [14:0]        duty_c,
    output logic [2:0]         sector,
    output logic signed [9:0]  d_voltage
);
    import foc_pkg::*;

    seq_state_t state_reg, state_next;

    // Captured input word.
    logic signed [15:0] ia_reg, ib_reg, sn_reg, cs_reg, vq_reg;

    // Loop state kept from one period to the next.
    logic signed [15:0] filt_reg, flux_reg;

    // Intermediate results.
    logic signed [9:0]  vd_reg;
    logic signed [15:0] va_reg, xs_reg, y_reg, z_reg, zs_reg, ys_reg;
    logic [2:0]         sec_reg;

    // Output register.
    logic               out_valid_reg;
    logic [14:0]        duty_a_reg, duty_b_reg, duty_c_reg;
    logic [2:0]         sector_reg;
    logic signed [9:0]  d_voltage_reg;

    // Shared unit.
    mac_cmd_t                    cmd;
    logic signed [MAC_ACC_W-1:0] acc;

    // Control strobes from the sequencer.
    logic cap_filt, cap_reg, cap_va, cap_xs, cap_yz, cap_zs, cap_ys, out_load;

    foc_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .acc   (acc)
    );

    // Views of the accumulator after the fixed right shifts.
    logic signed [15:0] acc_q15;
    logic signed [17:0] acc_park;
    logic signed [16:0] acc_t;
    logic signed [15:0] acc_scl;

    assign acc_q15  = acc[30:15];
    assign acc_park = acc[32:15];
    assign acc_t    = acc[27:11];
    assign acc_scl  = acc[25:10];

    // Clarke input: ia + 2*ib.
    logic signed [17:0] beta_in;
    assign beta_in = {{2{ia_reg[15]}}, ia_reg} + {ib_reg[15], ib_reg, 1'b0};

    // Flux regulator: sign-step integrator plus a quarter of the negated d current.
    logic signed [15:0] neg_d, reg_step, flux_inc, reg_sum, reg_sum_c, flux_c, vd_shift;

    always_comb
    begin
        neg_d = -filt_reg;
        if (neg_d[15])
        begin
            reg_step = -16'sd1;
        end
        else if (neg_d != 16'sd0)
        begin
            reg_step = 16'sd1;
        end
        else
        begin
            reg_step = 16'sd0;
        end
        flux_inc = flux_reg + reg_step;
        reg_sum  = flux_inc + (neg_d >>> 2);
        if (reg_sum < REG_NEG)
        begin
            reg_sum_c = REG_NEG;
            flux_c    = REG_NEG;
        end
        else if (reg_sum > REG_POS)
        begin
            reg_sum_c = REG_POS;
            flux_c    = REG_POS;
        end
        else
        begin
            reg_sum_c = reg_sum;
            flux_c    = flux_inc;
        end
        vd_shift = reg_sum_c >>> 6;
    end

    // Space-vector Y and Z terms and the sector code.
    logic signed [17:0] va_ext, t_ext, y_full, z_full;
    logic signed [15:0] y_w, z_w;
    logic [2:0]         sec_next;

    always_comb
    begin
        va_ext   = 18'(va_reg);
        t_ext    = 18'(acc_t);
        y_full   = t_ext - va_ext;
        z_full   = -(va_ext + t_ext);
        y_w      = y_full[15:0];
        z_w      = z_full[15:0];
        sec_next = {(z_w > 16'sd0), (y_w > 16'sd0), (va_reg > 16'sd0)};
    end

    // Halved negations of Z and Y ahead of their scaling.
    logic signed [16:0] hz, hy;
    assign hz = (-17'(z_reg)) >>> 1;
    assign hy = (-17'(y_reg)) >>> 1;

    // Duty assembly per sector.
    logic signed [17:0] xe, ye, ze, full_e, ta_full, tb_full, tc_full;
    logic signed [15:0] ta_w, tb_w, tc_w;
    logic [14:0]        ta_c, tb_c, tc_c;

    always_comb
    begin
        xe     = 18'(xs_reg);
        ye     = 18'(ys_reg);
        ze     = 18'(zs_reg);
        full_e = 18'(K_SVM_FULL);
        case (sec_reg) inside
            SEC_X, SEC_YZ:
            begin
                ta_full = full_e - ye + ze;
                tb_full = ye + full_e + ze;
                tc_full = full_e - ye - ze;
            end
            SEC_Y, SEC_XZ:
            begin
                ta_full = full_e - xe + ze;
                tb_full = full_e - ze + xe;
                tc_full = full_e - ze - xe;
            end
            SEC_XY, SEC_Z:
            begin
                ta_full = full_e - ye + xe;
                tb_full = ye + full_e + xe;
                tc_full = full_e - xe + ye;
            end
            default:
            begin
                ta_full = full_e;
                tb_full = full_e;
                tc_full = full_e;
            end
        endcase
        ta_w = ta_full[15:0];
        tb_w = tb_full[15:0];
        tc_w = tc_full[15:0];
        ta_c = ta_w[15] ? 15'd0 : ta_w[14:0];
        tb_c = tb_w[15] ? 15'd0 : tb_w[14:0];
        tc_c = tc_w[15] ? 15'd0 : tc_w[14:0];
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    state_next = in_valid ? ST_BETA : ST_IDLE;
            ST_BETA:    state_next = ST_PARK_A;
            ST_PARK_A:  state_next = ST_PARK_B;
            ST_PARK_B:  state_next = ST_FILT_A;
            ST_FILT_A:  state_next = ST_FILT_B;
            ST_FILT_B:  state_next = ST_VA_Q;
            ST_VA_Q:    state_next = ST_FILT_WR;
            ST_FILT_WR: state_next = ST_REG;
            ST_REG:     state_next = ST_VA_D;
            ST_VA_D:    state_next = ST_VB_D;
            ST_VB_D:    state_next = ST_VB_Q;
            ST_VB_Q:    state_next = ST_XS;
            ST_XS:      state_next = ST_T;
            ST_T:       state_next = ST_XS_WR;
            ST_XS_WR:   state_next = ST_YZ;
            ST_YZ:      state_next = ST_ZS;
            ST_ZS:      state_next = ST_YS;
            ST_YS:      state_next = ST_ZS_WR;
            ST_ZS_WR:   state_next = ST_YS_WR;
            ST_YS_WR:   state_next = ST_OUT;
            ST_OUT:     state_next = (!out_valid_reg || out_ready) ? ST_IDLE : ST_OUT;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: MAC commands and capture strobes.
    always_comb
    begin
        cmd      = '0;
        cmd.mode = MAC_LOAD;
        in_ready = 1'b0;
        cap_filt = 1'b0;
        cap_reg  = 1'b0;
        cap_va   = 1'b0;
        cap_xs   = 1'b0;
        cap_yz   = 1'b0;
        cap_zs   = 1'b0;
        cap_ys   = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_BETA:
            begin
                cmd.vld = 1'b1;
                cmd.a   = beta_in;
                cmd.b   = K_BETA;
            end
            ST_PARK_A:
            begin
                cmd.vld = 1'b1;
                cmd.a   = MAC_A_W'(ia_reg);
                cmd.b   = cs_reg;
            end
            ST_PARK_B:
            begin
                cmd.vld  = 1'b1;
                cmd.mode = MAC_ADD;
                cmd.a    = MAC_A_W'(acc_q15);
                cmd.b    = sn_reg;
            end
            ST_FILT_A:
            begin
                cmd.vld = 1'b1;
                cmd.a   = MAC_A_W'(filt_reg);
                cmd.b   = K_FILT_OLD;
            end
            ST_FILT_B:
            begin
                cmd.vld  = 1'b1;
                cmd.mode = MAC_ADD;
                cmd.a    = acc_park;
                cmd.b    = K_FILT_NEW;
            end
            ST_VA_Q:
            begin
                cmd.vld = 1'b1;
                cmd.a   = MAC_A_W'(vq_reg);
                cmd.b   = cs_reg;
            end
            ST_FILT_WR:
            begin
                cap_filt = 1'b1;
            end
            ST_REG:
            begin
                cap_reg = 1'b1;
            end
            ST_VA_D:
            begin
                cmd.vld  = 1'b1;
                cmd.mode = MAC_ADD;
                cmd.a    = MAC_A_W'(vd_reg);
                cmd.b    = sn_reg;
            end
            ST_VB_D:
            begin
                cmd.vld = 1'b1;
                cmd.a   = MAC_A_W'(vd_reg);
                cmd.b   = cs_reg;
            end
            ST_VB_Q:
            begin
                cmd.vld  = 1'b1;
                cmd.mode = MAC_SUB;
                cmd.a    = MAC_A_W'(vq_reg);
                cmd.b    = sn_reg;
                cap_va   = 1'b1;
            end
            ST_XS:
            begin
                cmd.vld = 1'b1;
                cmd.a   = MAC_A_W'(va_reg);
                cmd.b   = K_SVM_FULL;
            end
            ST_T:
            begin
                cmd.vld = 1'b1;
                cmd.a   = MAC_A_W'(acc_q15);
                cmd.b   = K_SQRT3;
            end
            ST_XS_WR:
            begin
                cap_xs = 1'b1;
            end
            ST_YZ:
            begin
                cap_yz = 1'b1;
            end
            ST_ZS:
            begin
                cmd.vld = 1'b1;
                cmd.a   = MAC_A_W'(hz);
                cmd.b   = K_SVM_FULL;
            end
            ST_YS:
            begin
                cmd.vld = 1'b1;
                cmd.a   = MAC_A_W'(hy);
                cmd.b   = K_SVM_FULL;
            end
            ST_ZS_WR:
            begin
                cap_zs = 1'b1;
            end
            ST_YS_WR:
            begin
                cap_ys = 1'b1;
            end
            ST_OUT:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Input word capture.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ia_reg <= phase_a_current;
            ib_reg <= phase_b_current;
            sn_reg <= angle_sine;
            cs_reg <= angle_cosine;
            vq_reg <= q_voltage_cmd;
        end
    end

    // Filter and integrator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg <= 16'sd0;
            flux_reg <= 16'sd0;
        end
        else
        begin
            if (cap_filt)
            begin
                filt_reg <= acc_q15;
            end
            if (cap_reg)
            begin
                flux_reg <= flux_c;
            end
        end
    end

    // Intermediate captures.
    always_ff @(posedge clk)
    begin
        if (cap_reg)
        begin
            vd_reg <= vd_shift[9:0];
        end
        if (cap_va)
        begin
            va_reg <= acc_q15;
        end
        if (cap_xs)
        begin
            xs_reg <= acc_scl;
        end
        if (cap_yz)
        begin
            y_reg   <= y_w;
            z_reg   <= z_w;
            sec_reg <= sec_next;
        end
        if (cap_zs)
        begin
            zs_reg <= acc_scl;
        end
        if (cap_ys)
        begin
            ys_reg <= acc_scl;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            duty_a_reg    <= ta_c;
            duty_b_reg    <= tb_c;
            duty_c_reg    <= tc_c;
            sector_reg    <= sec_reg;
            d_voltage_reg <= vd_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign duty_a    = duty_a_reg;
    assign duty_b    = duty_b_reg;
    assign duty_c    = duty_c_reg;
    assign sector    = sector_reg;
    assign d_voltage = d_voltage_reg;

    // A word once taken keeps the block busy on the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted again right after an accept");

    // The regulator clamp bounds the d voltage.
    a_vd_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (d_voltage >= -10'sd256) && (d_voltage <= 10'sd256))
        else $error("d voltage outside the regulator clamp");

    // Without a valid sector the duties sit at full scale.
    a_no_sector_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (sector == SEC_NONE || sector == SEC_ALL) |->
            duty_a == 15'd255 && duty_b == 15'd255 && duty_c == 15'd255)
        else $error("duties not at full scale for an empty or full sector code");

endmodule

// ===== rtl/foc_mac.sv =====
// Shared signed multiply-accumulate unit with a registered product stage.
`timescale 1ns / 1ps

module foc_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  foc_pkg::mac_cmd_t                   cmd,
    output logic signed [foc_pkg::MAC_ACC_W-1:0] acc
);
    import foc_pkg::*;

    logic signed [MAC_P_W-1:0]   prod_reg;
    mac_mode_t                   mode_reg;
    logic                        vld_reg;
    logic signed [MAC_ACC_W-1:0] acc_reg;
    logic signed [MAC_ACC_W-1:0] acc_next;
    logic signed [MAC_ACC_W-1:0] prod_ext;

    // The product valid flag is the registered command valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= cmd.vld;
        end
    end

    // Product stage.
    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(cmd.a) * $signed(cmd.b);
        mode_reg <= cmd.mode;
    end

    // Accumulate stage.
    assign prod_ext = MAC_ACC_W'(prod_reg);

    always_comb
    begin
        unique case (mode_reg)
            MAC_LOAD: acc_next = prod_ext;
            MAC_ADD:  acc_next = acc_reg + prod_ext;
            MAC_SUB:  acc_next = acc_reg - prod_ext;
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== dv/foc_step_checker.sv =====
// Checker for the FOC step block: predicts every duty word and compares it with the output.
`timescale 1ns / 1ps

module foc_step_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] phase_a_current,
    input  logic signed [15:0] phase_b_current,
    input  logic signed [15:0] angle_sine,
    input  logic signed [15:0] angle_cosine,
    input  logic signed [15:0] q_voltage_cmd,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [14:0]        duty_a,
    input  logic [14:0]        duty_b,
    input  logic [14:0]        duty_c,
    input  logic [2:0]         sector,
    input  logic signed [9:0]  d_voltage,
    output int                 errors,
    output int                 outstanding,
    output int                 checked
);

    import foc_pkg::*;

    // Coefficients widened so that every product is formed exactly.
    localparam longint C_BETA     = K_BETA;
    localparam longint C_FILT_OLD = K_FILT_OLD;
    localparam longint C_FILT_NEW = K_FILT_NEW;
    localparam longint C_SQRT3    = K_SQRT3;
    localparam longint C_FULL     = K_SVM_FULL;
    localparam longint C_REG_POS  = REG_POS;
    localparam longint C_REG_NEG  = REG_NEG;

    typedef struct packed {
        logic [14:0] duty_a;
        logic [14:0] duty_b;
        logic [14:0] duty_c;
        logic [2:0]  sector;
        logic [9:0]  d_voltage;
    } svpwm_word_t;

    // Block state as the predictor tracks it.
    longint filt_d_cur;
    longint flux_acc;

    svpwm_word_t pending_duties[$];

    function automatic longint wrap16(input longint v);
        return longint'(shortint'(v));
    endfunction

    function automatic longint wrap32(input longint v);
        return longint'(int'(v));
    endfunction

    // One control period: Clarke, Park, filter, flux regulator, inverse Park, SVPWM.
    function automatic svpwm_word_t predict_svpwm(
        input logic signed [15:0] ia_in,
        input logic signed [15:0] ib_in,
        input logic signed [15:0] sn_in,
        input logic signed [15:0] cs_in,
        input logic signed [15:0] vq_in
    );
        longint ia, ib, sn, cs, vq;
        longint i_beta, park, neg_d, dir, sum, vd;
        longint v_alpha, v_beta, t, x, y, z, ta, tb, tc;
        logic [2:0]  sec;
        svpwm_word_t res;
        ia = ia_in;
        ib = ib_in;
        sn = sn_in;
        cs = cs_in;
        vq = vq_in;

        // Current transforms and the d-current low-pass filter.
        i_beta     = wrap16((C_BETA * (ia + 2 * ib)) >>> 15);
        park       = wrap32((ia * cs + i_beta * sn) >>> 15);
        filt_d_cur = wrap16((C_FILT_OLD * filt_d_cur + C_FILT_NEW * park) >>> 15);

        // Sign-step integrator plus proportional term, clamped at the regulator limits.
        neg_d    = wrap16(-filt_d_cur);
        dir      = (neg_d > 0) ? 1 : ((neg_d < 0) ? -1 : 0);
        flux_acc = wrap16(flux_acc + dir);
        sum      = wrap16(flux_acc + (neg_d >>> 2));
        if (sum < C_REG_NEG) begin
            sum      = C_REG_NEG;
            flux_acc = C_REG_NEG;
        end else if (sum > C_REG_POS) begin
            sum      = C_REG_POS;
            flux_acc = C_REG_POS;
        end
        vd = sum >>> 6;

        // Inverse Park.
        v_beta  = wrap16((vd * cs - vq * sn) >>> 15);
        v_alpha = wrap16((vq * cs + vd * sn) >>> 15);

        // Sector decision and the scaled X, Y, Z terms.
        t   = (C_SQRT3 * v_beta) >>> 11;
        x   = v_alpha;
        y   = wrap16(t - v_alpha);
        z   = wrap16(-(v_alpha + t));
        sec = {z > 0, y > 0, x > 0};
        x   = wrap16((C_FULL * x) >>> 10);
        z   = wrap16((C_FULL * ((-z) >>> 1)) >>> 10);
        y   = wrap16((C_FULL * ((-y) >>> 1)) >>> 10);

        case (sec)
            SEC_X, SEC_YZ:
            begin
                ta = C_FULL - y + z;
                tb = y + C_FULL + z;
                tc = C_FULL - y - z;
            end
            SEC_Y, SEC_XZ:
            begin
                ta = C_FULL - x + z;
                tb = C_FULL - z + x;
                tc = C_FULL - z - x;
            end
            SEC_XY, SEC_Z:
            begin
                ta = C_FULL - y + x;
                tb = y + C_FULL + x;
                tc = C_FULL - x + y;
            end
            default:
            begin
                ta = C_FULL;
                tb = C_FULL;
                tc = C_FULL;
            end
        endcase

        // Duties wrap to 16 bits and are clamped at zero.
        ta = wrap16(ta);
        tb = wrap16(tb);
        tc = wrap16(tc);
        if (ta < 0) ta = 0;
        if (tb < 0) tb = 0;
        if (tc < 0) tc = 0;

        res.duty_a    = ta[14:0];
        res.duty_b    = tb[14:0];
        res.duty_c    = tc[14:0];
        res.sector    = sec;
        res.d_voltage = vd[9:0];
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Compare each output word with the oldest prediction, then predict for a new input word.
    always @(posedge clk or negedge rst_n)
    begin
        svpwm_word_t want;
        if (!rst_n) begin
            pending_duties.delete();
            filt_d_cur  = 0;
            flux_acc    = 0;
            errors      = 0;
            checked     <= 0;
            outstanding <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (pending_duties.size() == 0) begin
                    $error("output word with no input word outstanding");
                    errors++;
                end else begin
                    want = pending_duties.pop_front();
                    check_field("duty_a", want.duty_a, duty_a);
                    check_field("duty_b", want.duty_b, duty_b);
                    check_field("duty_c", want.duty_c, duty_c);
                    check_field("sector", want.sector, sector);
                    check_field("d_voltage", $signed(want.d_voltage), d_voltage);
                    checked <= checked + 1;
                end
            end
            if (in_valid && in_ready)
                pending_duties.push_back(predict_svpwm(phase_a_current, phase_b_current,
                                                       angle_sine, angle_cosine,
                                                       q_voltage_cmd));
            outstanding <= pending_duties.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the FOC step testbench: clock, reset, stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int QUIET_LIMIT  = 5000;
    localparam int RANDOM_WORDS = 1500;
    // Words in each half of the steady stretch without idling.
    localparam int WIND_UP_POS  = 150;
    localparam int WIND_UP_NEG  = 150;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] phase_a_current = '0;
    logic signed [15:0] phase_b_current = '0;
    logic signed [15:0] angle_sine = '0;
    logic signed [15:0] angle_cosine = '0;
    logic signed [15:0] q_voltage_cmd = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [14:0]        duty_a;
    logic [14:0]        duty_b;
    logic [14:0]        duty_c;
    logic [2:0]         sector;
    logic signed [9:0]  d_voltage;

    int   errors;
    int   outstanding;
    int   checked;
    int   words_sent = 0;
    logic steady_flow = 1'b0;

    foc_current_to_svpwm_step dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .phase_a_current (phase_a_current),
        .phase_b_current (phase_b_current),
        .angle_sine      (angle_sine),
        .angle_cosine    (angle_cosine),
        .q_voltage_cmd   (q_voltage_cmd),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .duty_a          (duty_a),
        .duty_b          (duty_b),
        .duty_c          (duty_c),
        .sector          (sector),
        .d_voltage       (d_voltage)
    );

    foc_step_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .phase_a_current (phase_a_current),
        .phase_b_current (phase_b_current),
        .angle_sine      (angle_sine),
        .angle_cosine    (angle_cosine),
        .q_voltage_cmd   (q_voltage_cmd),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .duty_a          (duty_a),
        .duty_b          (duty_b),
        .duty_c          (duty_c),
        .sector          (sector),
        .d_voltage       (d_voltage),
        .errors          (errors),
        .outstanding     (outstanding),
        .checked         (checked)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Output side stalls at random except during the steady stretch.
    always @(posedge clk)
    begin
        out_ready <= steady_flow || ($urandom_range(99) >= 34);
    end

    // Ends the run when no word moves on either channel for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("foc_current_to_svpwm_step regression: fail");
        $finish;
    end

    // Presents one input word, idling first at random, and waits until it is taken.
    task automatic send_word(
        input logic signed [15:0] ia,
        input logic signed [15:0] ib,
        input logic signed [15:0] sn,
        input logic signed [15:0] cs,
        input logic signed [15:0] vq
    );
        while (!steady_flow && $urandom_range(99) < 34) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        phase_a_current <= ia;
        phase_b_current <= ib;
        angle_sine      <= sn;
        angle_cosine    <= cs;
        q_voltage_cmd   <= vq;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Field value: full range, a moderate span, or a corner of the range.
    function automatic logic signed [15:0] pick_field(input int mode, input int span);
        logic signed [15:0] v;
        if (mode < 50) begin
            v = 16'($urandom());
        end else if (mode < 80) begin
            v = 16'(int'($urandom_range(2 * span)) - span);
        end else begin
            case ($urandom_range(6))
                0:       v = -16'sd32768;
                1:       v = -16'sd32767;
                2:       v = -16'sd1;
                3:       v = 16'sd0;
                4:       v = 16'sd1;
                5:       v = 16'sd32766;
                default: v = 16'sd32767;
            endcase
        end
        return v;
    endfunction

    initial
    begin
        int mode;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: range extremes, sector zero, the wrapped sector, every sector.
        send_word(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_word(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_word(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_word(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
        send_word(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
        send_word(16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1);
        send_word(16'sd9000, -16'sd7000, 16'sd0, 16'sd0, 16'sd12345);
        send_word(16'sd0, 16'sd0, -16'sd20209, 16'sd5000, 16'sd32767);
        send_word(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 16'sd100);
        send_word(16'sd2000, 16'sd1000, 16'sd0, 16'sd32767, 16'sd20000);
        send_word(16'sd2000, 16'sd1000, 16'sd28377, 16'sd16384, 16'sd20000);
        send_word(16'sd2000, 16'sd1000, 16'sd28377, -16'sd16384, 16'sd20000);
        send_word(16'sd2000, 16'sd1000, 16'sd0, -16'sd32768, 16'sd20000);
        send_word(16'sd2000, 16'sd1000, -16'sd28377, -16'sd16384, 16'sd20000);
        send_word(16'sd2000, 16'sd1000, -16'sd28377, 16'sd16384, 16'sd20000);
        send_word(-16'sd3000, 16'sd500, 16'sd16384, 16'sd28377, -16'sd32768);
        send_word(-16'sd3000, 16'sd500, -16'sd16384, -16'sd28377, 16'sd32767);
        send_word(16'sd0, 16'sd0, 16'sd23170, 16'sd23170, -16'sd32768);

        // Random traffic with idling on both sides.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            mode = $urandom_range(99);
            send_word(pick_field(mode, 4096), pick_field(mode, 4096),
                      pick_field(mode, 32767), pick_field(mode, 32767),
                      pick_field(mode, 24000));
        end

        // Steady stretch with no idling: drive the d current to full scale in one
        // direction, then in the other, so the integrator ramps both ways.
        steady_flow <= 1'b1;
        for (int i = 0; i < WIND_UP_POS; i++)
            send_word(-16'sd32768, 16'($urandom()), 16'sd0, 16'sd32767, 16'($urandom()));
        for (int i = 0; i < WIND_UP_NEG; i++)
            send_word(16'sd32767, 16'($urandom()), 16'sd0, 16'sd32767, 16'($urandom()));
        in_valid <= 1'b0;

        // Drain, then allow time for any stray output word.
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (60) @(posedge clk);

        $display("Sent %0d words: corner cases, random traffic with stalls, and a stretch",
                 words_sent);
        $display("without stalls at full-scale d current both ways; %0d duty words checked.",
                 checked);
        if (errors == 0)
            $display("foc_current_to_svpwm_step regression: pass");
        else
            $display("foc_current_to_svpwm_step regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/foc_pkg.sv
rtl/foc_mac.sv
rtl/foc_current_to_svpwm_step.sv
dv/foc_step_checker.sv
dv/testbench.sv
